/* hdl/dq_pkg.sv */
// dq_pkg: shared types, constants and ring arithmetic for the deque
// no dependencies; imported by dq_ctrl, dq_dp and double_ended_queue, not by dq_ram
`default_nettype none

package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_LIST_FWD   = 3'd4,
        REQ_LIST_BWD   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    typedef enum logic [2:0] {
        SRC_ACK,
        SRC_FULL,
        SRC_EMPTY,
        SRC_POP,
        SRC_LIST
    } t_out_src;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
        logic                     last;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic     wr_front;
        logic     wr_back;
        logic     pop_front;
        logic     pop_back;
        logic     list_rd;
        logic     list_init;
        logic     list_dir;   // 1 lists back to front
        logic     out_load;
        t_out_src out_src;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic list_last;
    } t_dp_stat;

    // position a steps after p, both below CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] p,
                                                  input logic [IDX_W-1:0] a);
        logic [IDX_W:0] s;
        s = {1'b0, p} + {1'b0, a};
        if (s >= (IDX_W+1)'(CAPACITY)) begin
            s = s - (IDX_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/dq_ram.sv */
// dq_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/dq_ctrl.sv */
// dq_ctrl: request sequencer of the deque
// depends on dq_pkg; drives the datapath through t_dp_cmd
`default_nettype none

module dq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [2:0]        i_req_type,
    input  wire dq_pkg::t_dp_stat  i_stat,
    output logic                   o_in_ready,
    output dq_pkg::t_dp_cmd        o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_src = SRC_ACK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (accept) begin
                    case (i_req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_src = SRC_FULL;
                            end else begin
                                o_cmd.out_src  = SRC_ACK;
                                o_cmd.wr_front = (i_req_type == REQ_PUSH_FRONT);
                                o_cmd.wr_back  = (i_req_type == REQ_PUSH_BACK);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_src  = SRC_EMPTY;
                            end else begin
                                o_cmd.pop_front = (i_req_type == REQ_POP_FRONT);
                                o_cmd.pop_back  = (i_req_type == REQ_POP_BACK);
                                n_state = S_POP;
                            end
                        end
                        REQ_LIST_FWD, REQ_LIST_BWD: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_src  = SRC_EMPTY;
                            end else begin
                                o_cmd.list_rd   = 1'b1;
                                o_cmd.list_init = 1'b1;
                                o_cmd.list_dir  = (i_req_type == REQ_LIST_BWD);
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            // unused codes are dropped
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = SRC_POP;
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = SRC_LIST;
                    if (i_stat.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.list_rd = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/dq_dp.sv */
// dq_dp: deque datapath, ring pointers, slot ram and output register
// depends on dq_pkg and dq_ram; controlled by dq_ctrl
`default_nettype none

module dq_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dq_pkg::t_dp_cmd    i_cmd,
    input  wire logic [31:0]        i_value,
    input  wire logic               i_out_ready,
    output dq_pkg::t_dp_stat        o_stat,
    output logic                    o_out_valid,
    output dq_pkg::t_out_beat       o_out_data
);
    import dq_pkg::*;

    logic [IDX_W-1:0]  r_front;
    logic [IDX_W-1:0]  n_front;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_dir;
    logic              r_last_rd;
    logic              r_out_valid;
    t_out_beat         r_out_data;

    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  idx_inc;
    logic              dir;
    logic [IDX_W-1:0]  fill_m1;
    logic [IDX_W-1:0]  list_off;
    logic [IDX_W-1:0]  front_m1;
    logic [IDX_W-1:0]  waddr;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic              re;
    logic [DATA_W-1:0] rdata;

    assign fill_m1  = IDX_W'(r_fill - CNT_W'(1));
    assign front_m1 = ring_add(r_front, IDX_W'(CAPACITY - 1));

    // list walk index
    assign idx      = i_cmd.list_init ? '0 : r_cnt;
    assign idx_inc  = idx + CNT_W'(1);
    assign dir      = i_cmd.list_init ? i_cmd.list_dir : r_dir;
    assign list_off = dir ? IDX_W'(r_fill - idx_inc) : IDX_W'(idx);

    assign we    = i_cmd.wr_front || i_cmd.wr_back;
    assign waddr = i_cmd.wr_front ? front_m1 : ring_add(r_front, IDX_W'(r_fill));
    assign re    = i_cmd.pop_front || i_cmd.pop_back || i_cmd.list_rd;

    always_comb begin
        if (i_cmd.pop_front) begin
            raddr = r_front;
        end else if (i_cmd.pop_back) begin
            raddr = ring_add(r_front, fill_m1);
        end else begin
            raddr = ring_add(r_front, list_off);
        end
    end

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_front = r_front;
        n_fill  = r_fill;
        if (i_cmd.wr_front) begin
            n_front = front_m1;
        end else if (i_cmd.pop_front) begin
            n_front = ring_add(r_front, IDX_W'(1));
        end
        if (we) begin
            n_fill = r_fill + CNT_W'(1);
        end else if (i_cmd.pop_front || i_cmd.pop_back) begin
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_fill  <= n_fill;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.list_rd) begin
            r_cnt     <= idx_inc;
            r_dir     <= dir;
            r_last_rd <= (idx_inc == r_fill);
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_src)
                SRC_POP: begin
                    r_out_data.value_out <= rdata;
                    r_out_data.status    <= STAT_OK;
                    r_out_data.last      <= 1'b1;
                end
                SRC_LIST: begin
                    r_out_data.value_out <= rdata;
                    r_out_data.status    <= STAT_OK;
                    r_out_data.last      <= r_last_rd;
                end
                SRC_FULL: begin
                    r_out_data.value_out <= '0;
                    r_out_data.status    <= STAT_FULL;
                    r_out_data.last      <= 1'b1;
                end
                SRC_EMPTY: begin
                    r_out_data.value_out <= '0;
                    r_out_data.status    <= STAT_EMPTY;
                    r_out_data.last      <= 1'b1;
                end
                default: begin
                    r_out_data.value_out <= '0;
                    r_out_data.status    <= STAT_OK;
                    r_out_data.last      <= 1'b1;
                end
            endcase
        end
    end

    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.full      = (r_fill == CNT_W'(CAPACITY));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.list_last = r_last_rd;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr_front, i_cmd.wr_back, i_cmd.pop_front,
                  i_cmd.pop_back, i_cmd.list_rd}))
        else $error("more than one ram operation in a cycle");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_front || i_cmd.wr_back) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("push did not grow the fill count");

endmodule

`default_nettype wire

/* hdl/double_ended_queue.sv */
// double_ended_queue: bounded deque of signed 32-bit values in a ring store
// depends on dq_pkg, dq_ctrl, dq_dp (which holds dq_ram)
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+----------------------------
//  in      | sink      | i_in_valid/o_in_ready  | t_in_beat  (req_type, value_in)
//  out     | source    | o_out_valid/i_out_ready| t_out_beat (value_out, status, last)
//
// push, refused push, and pop or list on an empty deque: result is in the
//   output register in the cycle after the request beat
// pop: the slot ram read is registered, then the value goes to the output register once it is free
// list of n values: after the first ram read, one result beat per cycle while the output is free,
//   paced by the single ram read port
// one request at a time: the next request beat is taken once the last result
//   of the current one has been loaded into the output register
// reset (synchronous, active low) empties the deque and front index goes to 0;
//   the slot ram is not cleared, only occupied slots are ever read
// a stall on the output holds the controller and the ram read data in place
`default_nettype none

module double_ended_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dq_pkg::t_in_beat  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dq_pkg::t_out_beat      o_out_data
);
    import dq_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // request sequencer: decides per beat what the datapath does
    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // ring pointers, slot ram and output register
    dq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in_data.value_in),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_double_ended_queue.sv */
// tb_double_ended_queue: self-checking bench for the bounded deque, directed script then
// random traffic, every result beat checked against its script row or an in-bench deque predictor
// depends on dq_pkg and double_ended_queue
`default_nettype none

module tb_double_ended_queue;
    import dq_pkg::*;

    // request codes the block has no use for, must be dropped without a result
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int HOLD_FILL  = 80;   // long receiver stall so the deque backs up
    localparam int HOLD_SHORT = 50;
    localparam int TAIL_WAIT  = 20;   // quiet cycles after the last result

    // ---------------------------------------------------------------- clock, reset, ports
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    always #5 clk = ~clk;

    double_ended_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    // ---------------------------------------------------------------- bench state
    t_out_beat due_beats [$];          // results still owed by the block, oldest first
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;             // receiver stall, counted down by the result monitor
    int n_errors      = 0;
    int n_reqs        = 0;
    int n_ignored     = 0;
    int n_beats       = 0;
    int n_full        = 0;
    int n_empty       = 0;
    int n_lists       = 0;
    int peak_fill     = 0;

    // ---------------------------------------------------------------- deque predictor
    logic signed [DATA_W-1:0] ring [CAPACITY];
    int head_slot = 0;                 // slot of the front value
    int fill      = 0;                 // values stored

    // apply one accepted request to the shadow deque; queue its results if asked
    task automatic deque_apply(input t_in_beat b, input bit record);
        t_out_beat r;
        int slot;
        r = '{value_out: '0, status: STAT_OK, last: 1'b1};
        case (b.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (fill == CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    if (b.req_type == REQ_PUSH_FRONT) begin
                        // front moves one slot back, wrapping below zero
                        head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                        ring[head_slot] = b.value_in;
                    end else begin
                        ring[(head_slot + fill) % CAPACITY] = b.value_in;
                    end
                    fill++;
                    if (fill > peak_fill) peak_fill = fill;
                end
                if (record) due_beats.push_back(r);
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    if (b.req_type == REQ_POP_FRONT) begin
                        slot      = head_slot;
                        head_slot = (head_slot + 1) % CAPACITY;
                    end else begin
                        slot = (head_slot + fill - 1) % CAPACITY;
                    end
                    r.value_out = ring[slot];
                    fill--;
                end
                if (record) due_beats.push_back(r);
            end
            REQ_LIST_FWD, REQ_LIST_BWD: begin
                n_lists++;
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                    if (record) due_beats.push_back(r);
                end else begin
                    for (int i = 0; i < fill; i++) begin
                        slot = (b.req_type == REQ_LIST_FWD) ? i : fill - 1 - i;
                        r.value_out = ring[(head_slot + slot) % CAPACITY];
                        r.last      = (i == fill - 1);
                        if (record) due_beats.push_back(r);
                    end
                end
            end
            default: begin
                n_ignored++;   // unused codes leave the deque alone
            end
        endcase
    endtask

    // ---------------------------------------------------------------- request side
    // one request beat: random gap, then valid held until the handshake
    // typed rows carry their own expected beat, the predictor only tracks state
    task automatic offer_beat(input logic [2:0] code, input logic signed [DATA_W-1:0] word,
                              input bit typed, input t_out_beat typed_beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{req_type: code, value_in: word};
        do @(posedge clk); while (!in_ready);
        deque_apply(in_beat, !typed);
        if (typed) due_beats.push_back(typed_beat);
        n_reqs++;
    endtask

    // sender pause: no request until every owed result has been seen
    task automatic await_drain();
        in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // mostly random words, now and then one of the extremes
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(11))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------- result side
    // compares each result beat with the oldest owed one and picks next ready
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && out_ready) begin
            n_beats++;
            if (due_beats.size() == 0) begin
                $error("result beat with nothing owed: value_out %0d status %0d last %0d",
                       out_beat.value_out, out_beat.status, out_beat.last);
                n_errors++;
            end else begin
                want = due_beats.pop_front();
                if (want.status == STAT_FULL)  n_full++;
                if (want.status == STAT_EMPTY) n_empty++;
                if (out_beat.value_out !== want.value_out) begin
                    $error("value_out: expected %0d, got %0d", want.value_out,
                           out_beat.value_out);
                    n_errors++;
                end
                if (out_beat.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_beat.status);
                    n_errors++;
                end
                if (out_beat.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_beat.last);
                    n_errors++;
                end
            end
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left  = hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- directed script
    typedef struct {
        logic [2:0]               code;
        logic signed [DATA_W-1:0] value;      // first value, steps by one per repeat
        int                       reps;
        bit                       typed;      // expected beat written in the row
        t_status                  want_status;
        logic signed [DATA_W-1:0] want_value;
    } t_row;

    t_row script [15] = '{
        // empty deque straight out of reset
        '{REQ_POP_FRONT,  32'sd0,            1,  1'b1, STAT_EMPTY, 32'sd0},
        '{REQ_POP_BACK,   32'sd0,            1,  1'b1, STAT_EMPTY, 32'sd0},
        '{REQ_LIST_FWD,   32'sd0,            1,  1'b1, STAT_EMPTY, 32'sd0},
        '{REQ_LIST_BWD,   32'sd0,            1,  1'b1, STAT_EMPTY, 32'sd0},
        // unused codes: no result at all
        '{REQ_SPARE_6,    32'sh12345678,     1,  1'b0, STAT_OK,    32'sd0},
        '{REQ_SPARE_7,    -32'sd1,           1,  1'b0, STAT_OK,    32'sd0},
        // front push from slot zero wraps to the top slot
        '{REQ_PUSH_FRONT, 32'sh80000000,     1,  1'b1, STAT_OK,    32'sd0},
        '{REQ_PUSH_BACK,  32'sh7fffffff,     1,  1'b1, STAT_OK,    32'sd0},
        // fill to capacity, values run through -1 and 0
        '{REQ_PUSH_FRONT, -32'sd7,           14, 1'b0, STAT_OK,    32'sd0},
        '{REQ_PUSH_BACK,  32'sd5,            1,  1'b1, STAT_FULL,  32'sd0},
        '{REQ_PUSH_FRONT, 32'sd9,            1,  1'b1, STAT_FULL,  32'sd0},
        // full-length lists both ways
        '{REQ_LIST_FWD,   32'sd0,            1,  1'b0, STAT_OK,    32'sd0},
        '{REQ_LIST_BWD,   32'sd0,            1,  1'b0, STAT_OK,    32'sd0},
        '{REQ_POP_BACK,   32'sd0,            1,  1'b1, STAT_OK,    32'sh7fffffff},
        '{REQ_POP_FRONT,  32'sd0,            1,  1'b0, STAT_OK,    32'sd0}
    };

    // ---------------------------------------------------------------- main sequence
    initial begin
        t_out_beat  want;
        logic [2:0] code;
        int         pick;
        int         counted;
        int         n_random;
        int         push_pct;
        int         quota [3];
        quota    = '{25, 24, 24};
        n_random = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily, for the script and the first phase
        send_idle_pct = 19;
        recv_idle_pct = 56;
        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                want = '{value_out: script[r].want_value, status: script[r].want_status,
                         last: 1'b1};
                offer_beat(script[r].code, script[r].value + k, script[r].typed, want);
            end
        end
        await_drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    hold_left = HOLD_FILL;   // back-pressure while requests keep coming
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_left     = HOLD_SHORT;
                end
            endcase
            counted = 0;
            while (counted < quota[ph]) begin
                // tide: stretches that lean toward filling, then toward draining
                push_pct = ((n_random / 16) % 2 == 0) ? 62 : 24;
                pick     = $urandom_range(99);
                if (pick < 4) begin
                    code = $urandom_range(1) ? REQ_SPARE_7 : REQ_SPARE_6;
                end else if (pick < 16) begin
                    code = $urandom_range(1) ? REQ_LIST_BWD : REQ_LIST_FWD;
                end else if (pick < 16 + push_pct) begin
                    code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                end else begin
                    code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
                end
                offer_beat(code, pick_word(), 1'b0, '0);
                if (code != REQ_SPARE_6 && code != REQ_SPARE_7) begin
                    counted++;
                    n_random++;
                end
            end
            await_drain();
        end

        // nothing owed any more; watch for stray beats a little longer
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d requests (%0d unused codes) and %0d result beats,",
                 n_reqs, n_ignored, n_beats);
        $display("with %0d lists, %0d full refusals, %0d empty reports, peak fill %0d",
                 n_lists, n_full, n_empty, peak_fill);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
